>>> rtl/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

  // Default number of slot address bits
  localparam int SLOT_BITS_DEF = 10;
  // Width of the slot_select and slot_index ports
  localparam int SLOT_IDX_W    = 10;
  // Config data width (widest register)
  localparam int CFG_W         = 4;
  // slot_count_log2 after reset
  localparam logic [CFG_W-1:0] SLOT_LOG2_RST = 4'd10;

  // Block index markers
  localparam logic [31:0] BLOCK_EMPTY   = 32'hFFFF_FFFF;
  localparam logic [31:0] BLOCK_DELETED = 32'hFFFF_FFFE;

  // Operation codes
  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_LOAD   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // Config register indexes
  typedef enum logic {
    CFG_TABLE_PRESENT = 1'b0,
    CFG_SLOT_LOG2     = 1'b1
  } cfg_idx_e;

  // One table slot as stored in memory
  typedef struct packed {
    logic [31:0] key_first;
    logic [31:0] key_second;
    logic [15:0] locale;
    logic [15:0] platform;
    logic [31:0] block;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/lpht_mem.sv
`default_nettype none

// Slot store: one write port, one read port, registered read data.
module lpht_mem #(
  parameter int SLOT_BITS = lpht_pkg::SLOT_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rd_en_i,
  input  wire [SLOT_BITS-1:0]  rd_addr_i,
  output lpht_pkg::entry_t     rd_data_o,
  input  wire                  wr_en_i,
  input  wire [SLOT_BITS-1:0]  wr_addr_i,
  input  lpht_pkg::entry_t     wr_data_i
);

  localparam int Depth = 1 << SLOT_BITS;

  lpht_pkg::entry_t mem [Depth];
  lpht_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/lpht_ctrl.sv
`default_nettype none

// Operation sequencer: probes one slot per cycle, rewrites the slot as deleted on a remove hit,
// fills the first free slot on insert, and sweeps the store on reset and on clear.
module lpht_ctrl #(
  parameter int SLOT_BITS = lpht_pkg::SLOT_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // command side
  input  wire                               start,
  output logic                              busy,
  input  wire  [2:0]                        operation_i,
  input  wire  [31:0]                       hash_a_i,
  input  wire  [31:0]                       hash_b_i,
  input  wire  [31:0]                       offset_hash_i,
  input  wire  [15:0]                       locale_code_i,
  input  wire                               use_locale_i,
  input  wire  [15:0]                       platform_code_i,
  input  wire  [31:0]                       block_number_i,
  input  wire  [lpht_pkg::SLOT_IDX_W-1:0]   slot_select_i,
  // config
  input  wire                               table_present_i,
  input  wire  [SLOT_BITS-1:0]              mask_i,
  // memory
  output logic                              rd_en_o,
  output logic [SLOT_BITS-1:0]              rd_addr_o,
  input  lpht_pkg::entry_t                  rd_data_i,
  output logic                              wr_en_o,
  output logic [SLOT_BITS-1:0]              wr_addr_o,
  output lpht_pkg::entry_t                  wr_data_o,
  // result
  output logic                              done_o,
  output logic                              ok_o,
  output logic [lpht_pkg::SLOT_IDX_W-1:0]   slot_index_o
);

  localparam int IdxW = lpht_pkg::SLOT_IDX_W;
  localparam int CmpW = (SLOT_BITS > IdxW) ? SLOT_BITS : IdxW;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_CLEAR = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [SLOT_BITS-1:0] idx_q, idx_d;
  logic [SLOT_BITS-1:0] cnt_q, cnt_d;
  logic                 report_q, report_d;
  logic                 done_q, done_d;
  logic                 ok_q, ok_d;
  logic [IdxW-1:0]      slot_q, slot_d;

  // captured command word
  lpht_pkg::op_e        op_q, op_d;
  logic [31:0]          ha_q, ha_d;
  logic [31:0]          hb_q, hb_d;
  logic [15:0]          loc_q, loc_d;
  logic                 use_loc_q, use_loc_d;
  logic [31:0]          blk_q, blk_d;

  lpht_pkg::op_e        op_in;
  logic [SLOT_BITS-1:0] start_idx;
  logic [SLOT_BITS-1:0] idx_nxt;
  logic [CmpW-1:0]      sel_ext;
  logic [CmpW-1:0]      mask_ext;
  logic                 sel_ok;
  logic                 slot_empty;
  logic                 slot_free;
  logic                 key_hit;
  logic                 last_probe;

  assign op_in     = lpht_pkg::op_e'(operation_i);
  assign start_idx = offset_hash_i[SLOT_BITS-1:0] & mask_i;
  assign idx_nxt   = (idx_q + SLOT_BITS'(1)) & mask_i;
  assign sel_ext   = CmpW'(slot_select_i);
  assign mask_ext  = CmpW'(mask_i);
  assign sel_ok    = (sel_ext & ~mask_ext) == '0;

  // slot classification on the word just read
  assign slot_empty = rd_data_i.block == lpht_pkg::BLOCK_EMPTY;
  assign slot_free  = rd_data_i.block >= lpht_pkg::BLOCK_DELETED;
  assign key_hit    = !slot_free
                   && rd_data_i.key_first == ha_q
                   && rd_data_i.key_second == hb_q
                   && (!use_loc_q || rd_data_i.locale == loc_q);
  assign last_probe = cnt_q == mask_i;

  assign busy = state_q != ST_IDLE;

  // next state and memory access
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    report_d  = report_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    slot_d    = slot_q;
    op_d      = op_q;
    ha_d      = ha_q;
    hb_d      = hb_q;
    loc_d     = loc_q;
    use_loc_d = use_loc_q;
    blk_d     = blk_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q;
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q;
    wr_data_o = '1;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d      = op_in;
          ha_d      = hash_a_i;
          hb_d      = hash_b_i;
          loc_d     = locale_code_i;
          use_loc_d = use_locale_i;
          blk_d     = block_number_i;
          if (!table_present_i) begin
            done_d = 1'b1;
            ok_d   = 1'b0;
            slot_d = '0;
          end else begin
            unique case (op_in)
              lpht_pkg::OP_LOOKUP, lpht_pkg::OP_INSERT, lpht_pkg::OP_REMOVE: begin
                // first probe read goes out with the accept
                rd_en_o   = 1'b1;
                rd_addr_o = start_idx;
                idx_d     = start_idx;
                cnt_d     = '0;
                state_d   = ST_PROBE;
              end
              lpht_pkg::OP_LOAD: begin
                done_d = 1'b1;
                if (sel_ok) begin
                  wr_en_o   = 1'b1;
                  wr_addr_o = sel_ext[SLOT_BITS-1:0];
                  wr_data_o = '{key_first: hash_a_i, key_second: hash_b_i,
                                locale: locale_code_i, platform: platform_code_i,
                                block: block_number_i};
                  ok_d      = 1'b1;
                  slot_d    = slot_select_i;
                end else begin
                  ok_d   = 1'b0;
                  slot_d = '0;
                end
              end
              lpht_pkg::OP_CLEAR: begin
                idx_d    = '0;
                report_d = 1'b1;
                state_d  = ST_CLEAR;
              end
              default: begin
                done_d = 1'b1;
                ok_d   = 1'b0;
                slot_d = '0;
              end
            endcase
          end
        end
      end

      ST_PROBE: begin
        // speculative read of the next slot; a write always ends the operation
        rd_en_o   = 1'b1;
        rd_addr_o = idx_nxt;
        idx_d     = idx_nxt;
        cnt_d     = cnt_q + SLOT_BITS'(1);
        unique case (op_q)
          lpht_pkg::OP_LOOKUP, lpht_pkg::OP_REMOVE: begin
            if (slot_empty) begin
              done_d  = 1'b1;
              ok_d    = 1'b0;
              slot_d  = '0;
              state_d = ST_IDLE;
            end else if (key_hit) begin
              if (op_q == lpht_pkg::OP_REMOVE) begin
                wr_en_o         = 1'b1;
                wr_addr_o       = idx_q;
                wr_data_o       = rd_data_i;
                wr_data_o.block = lpht_pkg::BLOCK_DELETED;
              end
              done_d  = 1'b1;
              ok_d    = 1'b1;
              slot_d  = IdxW'(idx_q);
              state_d = ST_IDLE;
            end else if (last_probe) begin
              done_d  = 1'b1;
              ok_d    = 1'b0;
              slot_d  = '0;
              state_d = ST_IDLE;
            end
          end
          lpht_pkg::OP_INSERT: begin
            if (slot_free) begin
              wr_en_o   = 1'b1;
              wr_addr_o = idx_q;
              wr_data_o = '{key_first: ha_q, key_second: hb_q, locale: loc_q,
                            platform: 16'h0000, block: blk_q};
              done_d    = 1'b1;
              ok_d      = 1'b1;
              slot_d    = IdxW'(idx_q);
              state_d   = ST_IDLE;
            end else if (last_probe) begin
              done_d  = 1'b1;
              ok_d    = 1'b0;
              slot_d  = '0;
              state_d = ST_IDLE;
            end
          end
          default: begin
            done_d  = 1'b1;
            ok_d    = 1'b0;
            slot_d  = '0;
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_CLEAR: begin
        // one slot per cycle back to all ones
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q;
        wr_data_o = '1;
        idx_d     = idx_q + SLOT_BITS'(1);
        if (idx_q == '1) begin
          state_d  = ST_IDLE;
          done_d   = report_q;
          ok_d     = 1'b1;
          slot_d   = '0;
          report_d = 1'b0;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state; sweep starts out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      idx_q    <= '0;
      cnt_q    <= '0;
      report_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      report_q <= report_d;
      done_q   <= done_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    slot_q    <= slot_d;
    op_q      <= op_d;
    ha_q      <= ha_d;
    hb_q      <= hb_d;
    loc_q     <= loc_d;
    use_loc_q <= use_loc_d;
    blk_q     <= blk_d;
  end

  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign slot_index_o = slot_q;

endmodule

`default_nettype wire

>>> rtl/linear_probe_hash_table.sv
// Lookup/insert/remove probe one slot per cycle, from the offset hash slot onward, through
// the single-read-port slot memory; load, unknown operations and no-table words need no probe.
// Clear holds busy while it writes every slot back to all ones (one slot per cycle), result after.
// One word at a time; busy is low again in the cycle the result shows on done_o.
// Reset: async active low; a sweep of every slot then empties the store (busy high).
// Results show on done_o for one cycle; the receiver cannot stall.
`default_nettype none

module linear_probe_hash_table #(
  parameter int SLOT_BITS = lpht_pkg::SLOT_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // config write port
  input  wire                               cfg_we_i,
  input  wire                               cfg_idx_i,
  input  wire  [lpht_pkg::CFG_W-1:0]        cfg_data_i,
  // command
  input  wire                               start,
  output logic                              busy,
  input  wire  [2:0]                        operation_i,
  input  wire  [31:0]                       hash_a_i,
  input  wire  [31:0]                       hash_b_i,
  input  wire  [31:0]                       offset_hash_i,
  input  wire  [15:0]                       locale_code_i,
  input  wire                               use_locale_i,
  input  wire  [15:0]                       platform_code_i,
  input  wire  [31:0]                       block_number_i,
  input  wire  [lpht_pkg::SLOT_IDX_W-1:0]   slot_select_i,
  // result
  output logic                              done_o,
  output logic                              ok_o,
  output logic [lpht_pkg::SLOT_IDX_W-1:0]   slot_index_o
);

  logic                       table_present_q;
  logic [lpht_pkg::CFG_W-1:0] slot_log2_q;
  logic [SLOT_BITS-1:0]       mask;

  logic                       rd_en;
  logic [SLOT_BITS-1:0]       rd_addr;
  lpht_pkg::entry_t           rd_data;
  logic                       wr_en;
  logic [SLOT_BITS-1:0]       wr_addr;
  lpht_pkg::entry_t           wr_data;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_present_q <= 1'b0;
      slot_log2_q     <= lpht_pkg::SLOT_LOG2_RST;
    end else if (cfg_we_i) begin
      unique case (lpht_pkg::cfg_idx_e'(cfg_idx_i))
        lpht_pkg::CFG_TABLE_PRESENT: table_present_q <= cfg_data_i[0];
        lpht_pkg::CFG_SLOT_LOG2:     slot_log2_q     <= cfg_data_i;
        default:                     table_present_q <= table_present_q;
      endcase
    end
  end

  // active slot mask; log2 above SLOT_BITS saturates to all ones
  always_comb begin
    for (int i = 0; i < SLOT_BITS; i++) begin
      mask[i] = int'(slot_log2_q) > i;
    end
  end

  lpht_ctrl #(
    .SLOT_BITS(SLOT_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .hash_a_i        (hash_a_i),
    .hash_b_i        (hash_b_i),
    .offset_hash_i   (offset_hash_i),
    .locale_code_i   (locale_code_i),
    .use_locale_i    (use_locale_i),
    .platform_code_i (platform_code_i),
    .block_number_i  (block_number_i),
    .slot_select_i   (slot_select_i),
    .table_present_i (table_present_q),
    .mask_i          (mask),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .done_o          (done_o),
    .ok_o            (ok_o),
    .slot_index_o    (slot_index_o)
  );

  lpht_mem #(
    .SLOT_BITS(SLOT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule

`default_nettype wire

>>> rtl/lpht_chk.sv
`default_nettype none

// Port-level checks on the command/result behavior.
module lpht_chk (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             start,
  input wire                             busy,
  input wire [2:0]                       operation_i,
  input wire [lpht_pkg::SLOT_IDX_W-1:0]  slot_select_i,
  input wire                             done_o,
  input wire                             ok_o,
  input wire [lpht_pkg::SLOT_IDX_W-1:0]  slot_index_o
);

  // accepted word is either answered next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted word neither answered nor busy");

  // a result only follows an accept or a busy cycle
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result without a pending word");

  // failed results carry slot zero
  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (slot_index_o == '0))
    else $error("failed result with nonzero slot");

  // a successful load reports the selected slot
  a_load_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == lpht_pkg::OP_LOAD) |=>
      (!(done_o && ok_o) || slot_index_o == $past(slot_select_i)))
    else $error("load reported wrong slot");

endmodule

bind linear_probe_hash_table lpht_chk u_chk (.*);

`default_nettype wire
